/* hdl/mersenne_twister_prng_top_assert.svh */
// Assertion macros for the MT19937 generator top level.
// Bodies refer to the clk and rst of the including module.
`ifndef MERSENNE_TWISTER_PRNG_TOP_ASSERT_SVH
`define MERSENNE_TWISTER_PRNG_TOP_ASSERT_SVH

// same-cycle implication
`define MTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/mtp_pkg.sv */
// Constants and word functions for the MT19937 generator.
// No dependencies; used by mtp_rsp_if and the top level.
package mtp_pkg;

  localparam int STATE_DEPTH   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int ADDR_W        = $clog2(STATE_DEPTH);
  localparam int WORD_W        = 32;

  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS   = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] LCG_MUL    = 32'd69069;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd4357;
  localparam logic [WORD_W-1:0] HALF_MASK  = 32'hffff_0000;

  // new state word from the joined pair and the word MIDDLE_OFFSET ahead
  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] y,
                                                   input logic [WORD_W-1:0] mid);
    logic [WORD_W-1:0] mix;
    mix = y[0] ? TWIST_XOR : '0;
    return mid ^ (y >> 1) ^ mix;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* hdl/mtp_if.sv */
// Request and result channel interfaces of the MT19937 generator.
// Depends on mtp_pkg for the word width.
interface mtp_req_if;
  logic valid;
  logic ready;
  logic reseed;

  modport source (output valid, output reseed, input ready);
  modport sink   (input valid, input reseed, output ready);
endinterface

interface mtp_rsp_if
  import mtp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

/* hdl/mersenne_twister_prng_top.sv */
// MT19937 generator top level: state memory, seeding LCG and twist/temper path.
// Depends on mtp_pkg, mtp_if.sv and mersenne_twister_prng_top_assert.svh.
//
// Usage:
//   req  : request channel; reseed = 1 refills the state from the seed first.
//   rsp  : result channel; one tempered word per request, in order.
//   cfg_we / cfg_wdata : seed register write (reset value 4357); a write
//     marks the state unseeded, so the next request refills it.
// Each word is twisted on the fly: three reads of the 624-word state memory
// (current, next and middle word) on its single read port, then one write
// back. A draw passes S_READ1, S_READ2 and S_WRITE on its way to the output
// register, and no new request is taken until it has returned to S_IDLE.
// A refill (first request after reset or a seed write, or reseed = 1) adds
// two LCG steps per state word on one multiplier, then one read (S_READ0).
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, a finished draw holds before its
// write-back until the register frees up.
// Reset clears control state only; the memory needs no clearing pass since
// every request is preceded by a fill until one has completed.
module mersenne_twister_prng_top
  import mtp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,
  mtp_req_if.sink           req,
  mtp_rsp_if.source         rsp
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_FILL_HI = 7'b0000010,
    S_FILL_LO = 7'b0000100,
    S_READ0   = 7'b0001000,
    S_READ1   = 7'b0010000,
    S_READ2   = 7'b0100000,
    S_WRITE   = 7'b1000000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_DEPTH - 1);

  state_t            state, state_next;
  logic [WORD_W-1:0] seed_value;
  logic              seeded;
  logic [ADDR_W-1:0] k;
  logic [ADDR_W-1:0] fill_addr;
  logic [WORD_W-1:0] lcg;
  logic [WORD_W-1:0] lcg_next;
  logic [15:0]       fill_hi;
  logic              y_hi;
  logic [WORD_W-2:0] y_lo;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;

  logic [WORD_W-1:0] mem [STATE_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              mem_we;

  logic              accept;
  logic              need_fill;
  logic              out_free;
  logic [ADDR_W-1:0] k_plus1;
  logic [ADDR_W:0]   mid_sum;
  logic [ADDR_W-1:0] k_mid;
  logic [WORD_W-1:0] new_word;

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign need_fill       = req.reseed || !seeded;
  assign out_free        = !out_valid || rsp.ready;
  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;

  assign lcg_next = WORD_W'(lcg * LCG_MUL) + WORD_W'(1);

  assign k_plus1 = (k == LAST_ADDR) ? '0 : k + ADDR_W'(1);
  assign mid_sum = {1'b0, k} + (ADDR_W + 1)'(MIDDLE_OFFSET);
  assign k_mid   = (mid_sum >= (ADDR_W + 1)'(STATE_DEPTH))
                   ? ADDR_W'(mid_sum - (ADDR_W + 1)'(STATE_DEPTH))
                   : mid_sum[ADDR_W-1:0];

  assign new_word = twist_word({y_hi, y_lo}, rd_data);

  // memory port selection
  always_comb begin
    rd_addr = k;
    wr_addr = k;
    wr_data = new_word;
    mem_we  = 1'b0;
    case (state)
      S_READ1:   rd_addr = k_plus1;
      S_READ2:   rd_addr = k_mid;
      S_WRITE: begin
        rd_addr = k_mid;
        mem_we  = out_free;
      end
      S_FILL_LO: begin
        wr_addr = fill_addr;
        wr_data = {fill_hi, lcg[WORD_W-1:16]};
        mem_we  = 1'b1;
      end
      default:   rd_addr = k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = need_fill ? S_FILL_HI : S_READ1;
        end
      end
      S_FILL_HI: state_next = S_FILL_LO;
      S_FILL_LO: state_next = (fill_addr == LAST_ADDR) ? S_READ0 : S_FILL_HI;
      S_READ0:   state_next = S_READ1;
      S_READ1:   state_next = S_READ2;
      S_READ2:   state_next = S_WRITE;
      S_WRITE:   state_next = out_free ? S_IDLE : S_WRITE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seed_value <= SEED_RESET;
      seeded     <= 1'b0;
      k          <= '0;
      fill_addr  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          fill_addr <= '0;
        end
        S_FILL_LO: begin
          fill_addr <= fill_addr + ADDR_W'(1);
          if (fill_addr == LAST_ADDR) begin
            seeded <= 1'b1;
            k      <= '0;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            k         <= k_plus1;
          end
        end
        default: begin
        end
      endcase

      // seed writes must arrive only while idle; the block itself does not enforce it
      if (cfg_we) begin
        seed_value <= cfg_wdata;
        seeded     <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE:    lcg <= seed_value;
      S_FILL_HI: begin
        fill_hi <= lcg[WORD_W-1:16];
        lcg     <= lcg_next;
      end
      S_FILL_LO: lcg <= lcg_next;
      S_READ1:   y_hi <= rd_data[WORD_W-1];
      S_READ2:   y_lo <= rd_data[WORD_W-2:0];
      S_WRITE: begin
        if (out_free) begin
          out_word <= temper(new_word);
        end
      end
      default: begin
      end
    endcase
  end

`include "mersenne_twister_prng_top_assert.svh"

  `MTP_ASSERT_NOW(a_index_in_range, 1'b1, k <= LAST_ADDR, "state index beyond depth")
  `MTP_ASSERT_NEXT(a_accept_busy, accept, !req.ready, "request taken while a word is in work")
  `MTP_ASSERT_NEXT(a_stall_holds, state == S_WRITE && !out_free, state == S_WRITE && out_valid, "stalled draw left write-back")
  `MTP_ASSERT_NEXT(a_fill_done, state == S_FILL_LO && fill_addr == LAST_ADDR, seeded && k == '0, "fill end did not restart index")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for mersenne_twister_prng_top: each drawn word is checked
// against a behavioural MT19937 generator that tracks the seed register.
// Depends on mtp_pkg and the channel interfaces in hdl/mtp_if.sv.
module tb_top;
  import mtp_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [WORD_W-1:0] cfg_wdata = '0;

  mtp_req_if req_ch ();
  mtp_rsp_if rsp_ch ();

  mersenne_twister_prng_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    req_ch.valid  = 1'b0;
    req_ch.reseed = 1'b0;
    rsp_ch.ready  = 1'b0;
  end

  // generator model: state, read position, seeded mark and seed register
  logic [WORD_W-1:0] mt_words [STATE_DEPTH];
  int unsigned       mt_pos = STATE_DEPTH;
  bit                mt_seeded = 1'b0;
  logic [WORD_W-1:0] seed_reg = SEED_RESET;

  bit                pending_reseeds [$];
  logic [WORD_W-1:0] words_due [$];
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  logic              hold_rsp = 1'b0;
  logic              squeeze = 1'b0;
  int unsigned       mismatches = 0;
  int unsigned       words_checked = 0;
  bit                next_reseed;
  logic [WORD_W-1:0] want;

  // upper halves of the seed and of successive 69069*s+1 values
  function automatic void lcg_fill(input logic [WORD_W-1:0] s0);
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] w;
    s = s0;
    for (int i = 0; i < STATE_DEPTH; i++) begin
      w = s & HALF_MASK;
      s = LCG_MUL * s + 32'd1;
      w = w | ((s & HALF_MASK) >> 16);
      s = LCG_MUL * s + 32'd1;
      mt_words[i] = w;
    end
    mt_pos    = STATE_DEPTH;
    mt_seeded = 1'b1;
  endfunction

  // in-place regeneration; later words see already-updated ones
  function automatic void regenerate();
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] mag;
    for (int k = 0; k < STATE_DEPTH; k++) begin
      y   = (mt_words[k] & HIGH_BIT) | (mt_words[(k + 1) % STATE_DEPTH] & LOW_BITS);
      mag = y[0] ? TWIST_XOR : {WORD_W{1'b0}};
      mt_words[k] = mt_words[(k + MIDDLE_OFFSET) % STATE_DEPTH] ^ (y >> 1) ^ mag;
    end
    mt_pos = 0;
  endfunction

  function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  function automatic logic [WORD_W-1:0] draw_word(input bit reseed);
    logic [WORD_W-1:0] w;
    if (reseed || !mt_seeded) lcg_fill(seed_reg);
    if (mt_pos >= STATE_DEPTH) regenerate();
    w = mt_words[mt_pos];
    mt_pos++;
    return tempered(w);
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] exp_word);
    mismatches++;
    $display("%0t mismatch on %s after %0d words: got %h, expected %h",
             $realtime, what, words_checked, got, exp_word);
  endtask

  // driver: prediction made as the word request is issued, so order holds
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid  <= 1'b0;
      req_ch.reseed <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_reseeds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_reseed = pending_reseeds.pop_front();
        words_due.push_back(draw_word(next_reseed));
        req_ch.valid  <= 1'b1;
        req_ch.reseed <= next_reseed;
      end else begin
        req_ch.valid  <= 1'b0;
        req_ch.reseed <= 1'($urandom_range(1));
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (words_due.size() == 0) begin
          report_mismatch("unrequested word", rsp_ch.random_word, 'x);
        end else begin
          want = words_due.pop_front();
          if (rsp_ch.random_word !== want)
            report_mismatch("random_word", rsp_ch.random_word, want);
        end
        words_checked++;
      end
      rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off while requests keep coming
  initial begin
    @(posedge clk);
    while (!squeeze) @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  task automatic wait_drained();
    while (pending_reseeds.size() != 0 || words_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] v);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    seed_reg  = v;
    mt_seeded = 1'b0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_words(input int unsigned n, input int unsigned reseed_pct);
    for (int i = 0; i < n; i++)
      pending_reseeds.push_back($urandom_range(99) < reseed_pct);
  endtask

  task automatic set_idling(input int unsigned snd, input int unsigned rcv);
    wait_drained();
    send_idle_pct = snd;
    stall_pct     = rcv;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset seed: first request fills from it, then an explicit reseed
    pending_reseeds = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    // a seed write leaves the state unseeded until the next request
    write_seed(32'h0000_0000);
    pending_reseeds = '{1'b0, 1'b1, 1'b0};
    write_seed(32'hffff_ffff);
    pending_reseeds = '{1'b1, 1'b0, 1'b0};
    write_seed(32'h8000_0001);
    pending_reseeds = '{1'b1, 1'b1, 1'b0};

    // long run without reseed
    write_seed($urandom);
    queue_words(270, 0);

    set_idling(68, 0);
    write_seed($urandom);
    queue_words(40, 8);

    set_idling(0, 68);
    write_seed($urandom);
    queue_words(40, 8);

    set_idling(31, 31);
    write_seed($urandom);
    queue_words(40, 8);

    // receiver blocked while requests keep coming; input must back up
    set_idling(0, 0);
    queue_words(40, 0);
    squeeze <= 1'b1;

    set_idling(0, 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    repeat (3_000_000) @(posedge clk);
    $display("FAIL");
    $finish;
  end

endmodule
